// ===== sv/sspc_pkg.sv =====
// Shared widths, reset values, register indexes and types for the servo scan
// position controller. Used by sspc_div and servo_scan_position_controller.
`timescale 1ns / 1ps

package sspc_pkg;

    // Field widths
    localparam int JOY_W      = 12;
    localparam int ECHO_W     = 16;
    localparam int PULSE_W    = 15;
    localparam int DIST_W     = 10;
    localparam int SSTEP_W    = 10;
    localparam int JSTEP_W    = 13;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] REG_BOUND_LO      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUND_HI      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADZONE_LOW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADZONE_HIGH = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DIVISOR_LOW   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DIVISOR_HIGH  = 3'd6;

    // Reset values
    localparam logic [PULSE_W-1:0] RST_BOUND_LO      = 15'd500;
    localparam logic [PULSE_W-1:0] RST_BOUND_HI      = 15'd2500;
    localparam logic [SSTEP_W-1:0] RST_SWEEP_STEP    = 10'd2;
    localparam logic [JOY_W-1:0]   RST_DEADZONE_LOW  = 12'd2900;
    localparam logic [JOY_W-1:0]   RST_DEADZONE_HIGH = 12'd3400;
    localparam logic [JOY_W-1:0]   RST_DIVISOR_LOW   = 12'd150;
    localparam logic [JOY_W-1:0]   RST_DIVISOR_HIGH  = 12'd37;
    localparam logic [PULSE_W-1:0] RST_POSITION      = 15'd1500;

    // Speed of sound: distance = echo * 343 / 20000
    localparam logic [8:0]         SOUND_NUM  = 9'd343;
    localparam int                 PROD_W     = ECHO_W + 9;
    localparam logic [ECHO_W-1:0]  ECHO_LIMIT = 16'd30000;

    // Shared divider: 24-bit dividend, 15-bit divisor, 12 quotient bits
    localparam int DIVD_W = 24;
    localparam int DIVS_W = 15;
    localparam int QUO_W  = 12;
    localparam logic [DIVS_W-1:0] SOUND_DEN = 15'd20000;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } sspc_div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } sspc_div_rsp_t;

endpackage

// ===== sv/sspc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sspc_pkg for widths and the request and response types.
`timescale 1ns / 1ps

module sspc_div
    import sspc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  sspc_div_req_t req,
    output sspc_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(QUO_W - 1);

    // The quotient must fit in QUO_W bits, so the upper dividend bits seed the
    // remainder and the lower ones are shifted through the quotient register.
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] diff;
    logic            fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = DIVS_W'(req.dividend[DIVD_W-1:QUO_W]);
            quo_next  = req.dividend[QUO_W-1:0];
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/servo_scan_position_controller.sv =====
// Top level of the servo scan position controller: configuration registers,
// step sequencer, servo position state and output register.
// Depends on sspc_pkg and instantiates the shared divider sspc_div.
`timescale 1ns / 1ps

// Usage
// Each slave-side transaction is one scan step: a joystick sample, an echo
// time and two toggle events. Each step yields exactly one master-side
// transaction with the reported pulse width, the distance in centimetres,
// the echo time passed through, a range error flag and the current route and
// mode. The toggles are applied first; in auto mode the position reported is
// the one before the sweep move, in manual mode the one after the joystick move.
// One step is handled at a time. The shared divider produces one quotient
// bit per cycle and is used once for the distance and, in manual mode
// outside the deadzone, once more for the joystick step. m_axis_tvalid and
// s_axis_tready rise at the same edge, when the result enters the output
// register, so a new step is taken only once the current one is finished.
// Reset returns the position to centre, sweeping up, auto mode and the wired
// route, and loads the default register values. When the receiver stalls the
// finished result waits in the output register, and a following step is
// carried through the sequencer but holds until the register is free.
// Configuration registers should be written only while no step is in flight.

module servo_scan_position_controller
    import sspc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] joystick, [27:12] echo_ticks, [28] toggle_route,
    // [29] toggle_motion, [31:30] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [14:0] servo width, [24:15] distance_cm, [40:25] echo_out,
    // [41] range_error, [42] route_wireless, [43] manual_active, [47:44] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL       = 3'd1;
    localparam logic [2:0] ST_DIST      = 3'd2;
    localparam logic [2:0] ST_DIST_WAIT = 3'd3;
    localparam logic [2:0] ST_JOY       = 3'd4;
    localparam logic [2:0] ST_JOY_WAIT  = 3'd5;
    localparam logic [2:0] ST_MOVE      = 3'd6;
    localparam logic [2:0] ST_HOLD      = 3'd7;

    // Configuration registers
    logic [PULSE_W-1:0] bound_lo_reg;
    logic [PULSE_W-1:0] bound_hi_reg;
    logic [SSTEP_W-1:0] sweep_step_reg;
    logic [JOY_W-1:0]   dz_low_reg;
    logic [JOY_W-1:0]   dz_high_reg;
    logic [JOY_W-1:0]   div_low_reg;
    logic [JOY_W-1:0]   div_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_lo_reg   <= RST_BOUND_LO;
            bound_hi_reg   <= RST_BOUND_HI;
            sweep_step_reg <= RST_SWEEP_STEP;
            dz_low_reg     <= RST_DEADZONE_LOW;
            dz_high_reg    <= RST_DEADZONE_HIGH;
            div_low_reg    <= RST_DIVISOR_LOW;
            div_high_reg   <= RST_DIVISOR_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BOUND_LO:      bound_lo_reg   <= cfg_data;
                REG_BOUND_HI:      bound_hi_reg   <= cfg_data;
                REG_SWEEP_STEP:    sweep_step_reg <= cfg_data[SSTEP_W-1:0];
                REG_DEADZONE_LOW:  dz_low_reg     <= cfg_data[JOY_W-1:0];
                REG_DEADZONE_HIGH: dz_high_reg    <= cfg_data[JOY_W-1:0];
                REG_DIVISOR_LOW:   div_low_reg    <= cfg_data[JOY_W-1:0];
                REG_DIVISOR_HIGH:  div_high_reg   <= cfg_data[JOY_W-1:0];
                default:           ;
            endcase
        end
    end

    // Control and servo state
    logic [2:0]          state_reg, state_next;
    logic [PULSE_W-1:0]  position_reg, position_next;
    logic                sweep_down_reg, sweep_down_next;
    logic                manual_reg, manual_next;
    logic                wireless_reg, wireless_next;
    logic                m_valid_reg, m_valid_next;

    // Step payload, held while the sequencer works on it
    logic [JOY_W-1:0]      joy_reg, joy_next;
    logic [ECHO_W-1:0]     echo_reg, echo_next;
    logic [DIVD_W-1:0]     prod_reg, prod_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic [JSTEP_W-1:0]    jstep_reg, jstep_next;
    logic [PULSE_W-1:0]    report_reg, report_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    sspc_div_req_t div_req;
    sspc_div_rsp_t div_rsp;

    sspc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic               in_accept;
    logic               out_free;
    logic               joy_below;
    logic               joy_above;
    logic [JOY_W-1:0]   joy_offset;
    logic [JOY_W-1:0]   joy_divisor;
    logic [PROD_W-1:0]  product;
    logic               range_err;
    logic [DIST_W-1:0]  dist_out;

    // Wide intermediate values of the position update
    logic [PULSE_W:0]   min_plus_j;
    logic [PULSE_W:0]   pos_plus_j;
    logic [PULSE_W:0]   pos_plus_s;
    logic [PULSE_W:0]   min_plus_s;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    // The downward deflection test takes priority when the deadzone is crossed.
    assign joy_below  = (joy_reg < dz_low_reg);
    assign joy_above  = !joy_below && (joy_reg > dz_high_reg);
    assign joy_offset = joy_below ? (dz_low_reg - joy_reg) : (joy_reg - dz_high_reg);

    // A divisor register of zero behaves as one.
    always_comb
    begin
        joy_divisor = joy_below ? div_low_reg : div_high_reg;
        if (joy_divisor == '0)
        begin
            joy_divisor = JOY_W'(1);
        end
    end

    assign product = echo_reg * SOUND_NUM;

    assign range_err = (echo_reg == '0) || (echo_reg > ECHO_LIMIT);
    assign dist_out  = range_err ? '0 : dist_reg;

    assign min_plus_j = {1'b0, bound_lo_reg} + {3'b000, jstep_reg};
    assign pos_plus_j = {1'b0, position_reg} + {3'b000, jstep_reg};
    assign pos_plus_s = {1'b0, position_reg} + {6'b000000, sweep_step_reg};
    assign min_plus_s = {1'b0, bound_lo_reg} + {6'b000000, sweep_step_reg};

    always_comb
    begin
        state_next      = state_reg;
        position_next   = position_reg;
        sweep_down_next = sweep_down_reg;
        manual_next     = manual_reg;
        wireless_next   = wireless_reg;
        m_valid_next    = m_valid_reg;
        joy_next        = joy_reg;
        echo_next       = echo_reg;
        prod_next       = prod_reg;
        dist_next       = dist_reg;
        jstep_next      = jstep_reg;
        report_next     = report_reg;
        m_data_next     = m_data_reg;

        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = SOUND_DEN;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // Toggles take effect before anything else in the step.
                    joy_next      = s_axis_tdata[11:0];
                    echo_next     = s_axis_tdata[27:12];
                    wireless_next = wireless_reg ^ s_axis_tdata[28];
                    manual_next   = manual_reg ^ s_axis_tdata[29];
                    state_next    = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // A large echo beyond the limit can overflow here; its distance is
                // discarded by the range check anyway.
                prod_next  = product[DIVD_W-1:0];
                state_next = ST_DIST;
            end

            ST_DIST:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIST_WAIT;
            end

            ST_DIST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dist_next = div_rsp.quotient[DIST_W-1:0];
                    if (manual_reg && (joy_below || joy_above))
                    begin
                        state_next = ST_JOY;
                    end
                    else
                    begin
                        jstep_next = '0;
                        state_next = ST_MOVE;
                    end
                end
            end

            ST_JOY:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {{(DIVD_W-JOY_W){1'b0}}, joy_offset};
                div_req.divisor  = {{(DIVS_W-JOY_W){1'b0}}, joy_divisor};
                state_next       = ST_JOY_WAIT;
            end

            ST_JOY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    jstep_next = {1'b0, div_rsp.quotient} + JSTEP_W'(1);
                    state_next = ST_MOVE;
                end
            end

            ST_MOVE:
            begin
                if (manual_reg)
                begin
                    if (joy_below)
                    begin
                        if (position_reg > bound_lo_reg)
                        begin
                            if ({1'b0, position_reg} > min_plus_j)
                            begin
                                position_next = position_reg - {2'b00, jstep_reg};
                            end
                            else
                            begin
                                position_next = bound_lo_reg;
                            end
                        end
                    end
                    else if (joy_above)
                    begin
                        if (position_reg < bound_hi_reg)
                        begin
                            if (pos_plus_j < {1'b0, bound_hi_reg})
                            begin
                                position_next = pos_plus_j[PULSE_W-1:0];
                            end
                            else
                            begin
                                position_next = bound_hi_reg;
                            end
                        end
                    end
                    report_next = position_next;
                end
                else
                begin
                    // Auto sweep reports the position before moving, and turns
                    // at a bound without passing it.
                    report_next = position_reg;
                    if (!sweep_down_reg)
                    begin
                        if (pos_plus_s >= {1'b0, bound_hi_reg})
                        begin
                            position_next   = bound_hi_reg;
                            sweep_down_next = 1'b1;
                        end
                        else
                        begin
                            position_next = pos_plus_s[PULSE_W-1:0];
                        end
                    end
                    else
                    begin
                        if ({1'b0, position_reg} <= min_plus_s)
                        begin
                            position_next   = bound_lo_reg;
                            sweep_down_next = 1'b0;
                        end
                        else
                        begin
                            position_next = position_reg - {5'b00000, sweep_step_reg};
                        end
                    end
                end
                state_next = ST_HOLD;
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_data_next  = {4'b0000, manual_reg, wireless_reg, range_err,
                                    echo_reg, dist_out, report_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            position_reg   <= RST_POSITION;
            sweep_down_reg <= 1'b0;
            manual_reg     <= 1'b0;
            wireless_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            position_reg   <= position_next;
            sweep_down_reg <= sweep_down_next;
            manual_reg     <= manual_next;
            wireless_reg   <= wireless_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joy_reg    <= joy_next;
        echo_reg   <= echo_next;
        prod_reg   <= prod_next;
        dist_reg   <= dist_next;
        jstep_reg  <= jstep_next;
        report_reg <= report_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== tb/servo_scan_position_controller_checker.sv =====
// Scoreboard for the servo scan position controller testbench: watches the
// register port and both stream channels, predicts each result and compares.
// Depends on sspc_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module servo_scan_position_controller_checker
    import sspc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [11:0] joystick, [27:12] echo_ticks, [28] toggle_route,
    // [29] toggle_motion, [31:30] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [14:0] servo width, [24:15] distance_cm, [40:25] echo_out,
    // [41] range_error, [42] route_wireless, [43] manual_active, [47:44] zero
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    in_flight,
    output int                    reports_checked
);

    // Declared from the top bit down so that the servo width lands in the lowest bits.
    typedef struct packed {
        logic               manual_active;
        logic               route_wireless;
        logic               range_error;
        logic [ECHO_W-1:0]  echo_out;
        logic [DIST_W-1:0]  distance_cm;
        logic [PULSE_W-1:0] servo_width;
    } scan_report_t;

    localparam int REPORT_W     = $bits(scan_report_t);
    localparam int ROUTE_BIT    = JOY_W + ECHO_W;
    localparam int MOTION_BIT   = JOY_W + ECHO_W + 1;
    localparam int REPORT_LIMIT = 10;

    int unsigned  lim_low, lim_high, stride, dz_lo, dz_hi, div_lo, div_hi;
    int unsigned  servo_pos;
    bit           heading_down, manual_on, wireless_on;
    scan_report_t pending_reports[$];
    int           fault_total, checked_total;

    // Applies one scan step to the shadow state and returns the result it causes.
    function automatic scan_report_t advance_scan_step(input logic [IN_DATA_W-1:0] word);
        int unsigned  joy;
        int unsigned  echo;
        int unsigned  nudge;
        int unsigned  shown;
        bit           no_echo;
        scan_report_t r;
        joy  = word[JOY_W-1:0];
        echo = word[JOY_W +: ECHO_W];
        if (word[ROUTE_BIT])
            wireless_on = !wireless_on;
        if (word[MOTION_BIT])
            manual_on = !manual_on;

        if (manual_on)
        begin
            // The downward test wins when the deadzone is crossed.
            if (joy < dz_lo)
            begin
                nudge = 1 + (dz_lo - joy) / ((div_lo == 0) ? 1 : div_lo);
                if (servo_pos > lim_low)
                    servo_pos = (servo_pos > lim_low + nudge) ? servo_pos - nudge : lim_low;
            end
            else if (joy > dz_hi)
            begin
                nudge = 1 + (joy - dz_hi) / ((div_hi == 0) ? 1 : div_hi);
                if (servo_pos < lim_high)
                    servo_pos = (servo_pos + nudge < lim_high) ? servo_pos + nudge : lim_high;
            end
            shown = servo_pos;
        end
        else
        begin
            // Auto sweep reports first, then moves and turns at the bounds.
            shown = servo_pos;
            if (!heading_down)
            begin
                if (servo_pos + stride >= lim_high)
                begin
                    servo_pos    = lim_high;
                    heading_down = 1'b1;
                end
                else
                    servo_pos = servo_pos + stride;
            end
            else if (servo_pos <= lim_low + stride)
            begin
                servo_pos    = lim_low;
                heading_down = 1'b0;
            end
            else
                servo_pos = servo_pos - stride;
        end

        no_echo          = (echo == 0) || (echo > ECHO_LIMIT);
        r.servo_width    = PULSE_W'(shown);
        r.distance_cm    = no_echo ? '0 : DIST_W'((echo * SOUND_NUM) / SOUND_DEN);
        r.echo_out       = ECHO_W'(echo);
        r.range_error    = no_echo;
        r.route_wireless = wireless_on;
        r.manual_active  = manual_on;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        scan_report_t seen;
        scan_report_t want;
        if (!rst_n)
        begin
            lim_low      = RST_BOUND_LO;
            lim_high     = RST_BOUND_HI;
            stride       = RST_SWEEP_STEP;
            dz_lo        = RST_DEADZONE_LOW;
            dz_hi        = RST_DEADZONE_HIGH;
            div_lo       = RST_DIVISOR_LOW;
            div_hi       = RST_DIVISOR_HIGH;
            servo_pos    = RST_POSITION;
            heading_down = 1'b0;
            manual_on    = 1'b0;
            wireless_on  = 1'b0;
            pending_reports.delete();
            fault_total     = 0;
            checked_total   = 0;
            mismatches      <= 0;
            in_flight       <= 0;
            reports_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BOUND_LO:      lim_low  = cfg_data[PULSE_W-1:0];
                    REG_BOUND_HI:      lim_high = cfg_data[PULSE_W-1:0];
                    REG_SWEEP_STEP:    stride   = cfg_data[SSTEP_W-1:0];
                    REG_DEADZONE_LOW:  dz_lo    = cfg_data[JOY_W-1:0];
                    REG_DEADZONE_HIGH: dz_hi    = cfg_data[JOY_W-1:0];
                    REG_DIVISOR_LOW:   div_lo   = cfg_data[JOY_W-1:0];
                    REG_DIVISOR_HIGH:  div_hi   = cfg_data[JOY_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                pending_reports.push_back(advance_scan_step(s_axis_tdata));

            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = scan_report_t'(m_axis_tdata[REPORT_W-1:0]);
                if (pending_reports.size() == 0)
                begin
                    fault_total = fault_total + 1;
                    if (fault_total <= REPORT_LIMIT)
                        $display("%0t: unexpected result, width %0d distance_cm %0d echo_out %0d",
                                 $time, seen.servo_width, seen.distance_cm, seen.echo_out);
                end
                else
                begin
                    want          = pending_reports.pop_front();
                    checked_total = checked_total + 1;
                    if (seen.servo_width != want.servo_width ||
                        seen.distance_cm != want.distance_cm ||
                        seen.echo_out != want.echo_out ||
                        seen.range_error != want.range_error ||
                        seen.route_wireless != want.route_wireless ||
                        seen.manual_active != want.manual_active)
                    begin
                        fault_total = fault_total + 1;
                        if (fault_total <= REPORT_LIMIT)
                        begin
                            $display("%0t: result %0d wrong (expected/actual): width %0d/%0d",
                                     $time, checked_total,
                                     want.servo_width, seen.servo_width);
                            $display("    distance_cm %0d/%0d echo_out %0d/%0d",
                                     want.distance_cm, seen.distance_cm,
                                     want.echo_out, seen.echo_out);
                            $display("    range_error %0b/%0b route_wireless %0b/%0b",
                                     want.range_error, seen.range_error,
                                     want.route_wireless, seen.route_wireless);
                            $display("    manual_active %0b/%0b",
                                     want.manual_active, seen.manual_active);
                        end
                    end
                end
            end

            mismatches      <= fault_total;
            in_flight       <= pending_reports.size();
            reports_checked <= checked_total;
        end
    end

endmodule

// ===== tb/servo_scan_position_controller_tb.sv =====
// Top of the servo scan position controller testbench: clock, reset, stimulus,
// receiver back-pressure and the final verdict.
// Depends on sspc_pkg, the controller RTL and servo_scan_position_controller_checker.
`timescale 1ns / 1ps

module servo_scan_position_controller_tb;
    import sspc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    // Set far above the length of an honest run; this leaves ample room.
    localparam int CYCLE_LIMIT    = 1000000;
    // Longer than a result with a joystick division needs, so this
    // comfortably covers anything the block could still be doing.
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PLANS      = 14;
    localparam int STEPS_PER_PLAN = 130;
    localparam int PHASE_A_END    = 607;
    localparam int PHASE_B_END    = 1214;
    localparam int HOLD_PLAN_A    = 2;
    localparam int HOLD_PLAN_B    = 9;
    localparam int PAUSE_PLAN     = 6;
    localparam int FIRST_RAND_PLAN = 9;
    localparam int LAST_RAND_PLAN  = 12;
    localparam int PULSE_TOP      = 20000;
    localparam int SSTEP_TOP      = 1000;
    localparam int JOY_FULL       = (1 << JOY_W) - 1;
    localparam int ECHO_FULL      = (1 << ECHO_W) - 1;

    // One complete set of register values, written together between phases.
    typedef struct packed {
        logic [PULSE_W-1:0] bound_lo;
        logic [PULSE_W-1:0] bound_hi;
        logic [SSTEP_W-1:0] sweep_step;
        logic [JOY_W-1:0]   dz_low;
        logic [JOY_W-1:0]   dz_high;
        logic [JOY_W-1:0]   div_low;
        logic [JOY_W-1:0]   div_high;
    } reg_plan_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [11:0] joystick, [27:12] echo_ticks, [28] toggle_route,
    // [29] toggle_motion, [31:30] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [14:0] servo width, [24:15] distance_cm, [40:25] echo_out,
    // [41] range_error, [42] route_wireless, [43] manual_active, [47:44] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int        mismatches;
    int        in_flight;
    int        reports_checked;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_asked;
    int        hold_served;
    int        steps_sent;
    reg_plan_t plans [NUM_PLANS];
    reg_plan_t live_plan;

    servo_scan_position_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    servo_scan_position_controller_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .in_flight       (in_flight),
        .reports_checked (reports_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver side. Normally it drops tready at random; when the stimulus asks
    // for a hold-off it keeps tready low for a long stretch counted here, so
    // the output register fills and the block has to stall its input.
    initial
    begin
        m_axis_tready <= 1'b0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_served + 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Cycle counter that ends a run which has hung.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("Run stopped by the cycle limit after %0d cycles.", cycles);
        $display("servo_scan_position_controller_tb: errors");
        $finish;
    end

    function automatic reg_plan_t make_plan(input int unsigned lo, hi, stride,
                                            dz_lo, dz_hi, div_lo, div_hi);
        reg_plan_t r;
        r.bound_lo   = PULSE_W'(lo);
        r.bound_hi   = PULSE_W'(hi);
        r.sweep_step = SSTEP_W'(stride);
        r.dz_low     = JOY_W'(dz_lo);
        r.dz_high    = JOY_W'(dz_hi);
        r.div_low    = JOY_W'(div_lo);
        r.div_high   = JOY_W'(div_hi);
        return r;
    endfunction

    // Offers one scan step and returns at the edge where the transaction is
    // accepted. tvalid is only lowered when a gap is actually taken, so
    // back-to-back steps keep it high without a glitch.
    task automatic send_step(input logic [JOY_W-1:0] joy, input logic [ECHO_W-1:0] echo,
                             input logic flip_route, input logic flip_mode);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tdata  <= {2'b00, flip_mode, flip_route, echo, joy};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        steps_sent = steps_sent + 1;
    endtask

    // Random step: joystick biased towards the full-scale ends and both
    // deadzone edges of the live settings, echo mostly in the valid range
    // with the range-error boundaries and the whole 16-bit span mixed in.
    task automatic send_random_step;
        int          joy;
        int unsigned echo;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            joy = ($urandom_range(0, 1) != 0) ? JOY_FULL : 0;
        else if (pick == 1)
            joy = int'(live_plan.dz_low) + int'($urandom_range(0, 2)) - 1;
        else if (pick == 2)
            joy = int'(live_plan.dz_high) + int'($urandom_range(0, 2)) - 1;
        else
            joy = $urandom_range(0, JOY_FULL);
        if (joy < 0)
            joy = 0;
        else if (joy > JOY_FULL)
            joy = JOY_FULL;

        pick = $urandom_range(0, 9);
        if (pick < 7)
            echo = $urandom_range(1, ECHO_LIMIT);
        else if (pick == 7)
        begin
            case ($urandom_range(0, 2))
                0:       echo = 0;
                1:       echo = ECHO_LIMIT;
                default: echo = ECHO_LIMIT + 1;
            endcase
        end
        else
            echo = $urandom_range(0, ECHO_FULL);

        send_step(JOY_W'(joy), ECHO_W'(echo),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 11) == 0);
    endtask

    // Leaves cfg_we high so that a run of writes needs no glitch on it;
    // load_plan lowers it after the last register.
    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_plan(input reg_plan_t plan);
        set_reg(REG_BOUND_LO,      plan.bound_lo);
        set_reg(REG_BOUND_HI,      plan.bound_hi);
        set_reg(REG_SWEEP_STEP,    plan.sweep_step);
        set_reg(REG_DEADZONE_LOW,  plan.dz_low);
        set_reg(REG_DEADZONE_HIGH, plan.dz_high);
        set_reg(REG_DIVISOR_LOW,   plan.div_low);
        set_reg(REG_DIVISOR_HIGH,  plan.div_high);
        cfg_we <= 1'b0;
        @(posedge clk);
        live_plan = plan;
    endtask

    // Stops offering steps and waits until every expected result has been
    // taken, then lets the block settle. The first edge lets the scoreboard
    // count a transaction accepted at the current edge.
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int p;
        int k;
        int rand_steps;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_data      <= '0;
        send_idle_pct <= 15;
        recv_idle_pct <= 49;
        hold_asked    <= 0;
        steps_sent = 0;
        live_plan  = make_plan(RST_BOUND_LO, RST_BOUND_HI, RST_SWEEP_STEP,
                               RST_DEADZONE_LOW, RST_DEADZONE_HIGH,
                               RST_DIVISOR_LOW, RST_DIVISOR_HIGH);

        // Register settings per phase. The fixed ones cover the defaults, the
        // field extremes, tight bounds that turn the sweep every few steps, a
        // zero sweep step with zero divisors (which act as one), crossed
        // bounds with a crossed deadzone, equal bounds, and bounds that leave
        // the position stranded outside them.
        plans[0]  = live_plan;
        plans[1]  = make_plan(1000, 1010, 3, 2048, 2048, 1, 1);
        plans[2]  = make_plan(0, PULSE_TOP, SSTEP_TOP, 0, JOY_FULL, JOY_FULL, JOY_FULL);
        plans[3]  = make_plan(100, 140, 0, 1000, 3000, 0, 0);
        plans[4]  = make_plan(3000, 2000, 7, 3500, 500, 200, 300);
        plans[5]  = make_plan(PULSE_TOP, 0, 1, JOY_FULL, 0, 1, 1);
        plans[6]  = make_plan(0, 0, 1, 2000, 2100, JOY_FULL, 1);
        plans[7]  = make_plan(PULSE_TOP, PULSE_TOP, SSTEP_TOP, JOY_FULL, JOY_FULL, 1, JOY_FULL);
        plans[8]  = make_plan(1500, 1600, 1, 3000, 3100, 50, 50);
        for (p = FIRST_RAND_PLAN; p <= LAST_RAND_PLAN; p++)
            plans[p] = make_plan($urandom_range(0, PULSE_TOP), $urandom_range(0, PULSE_TOP),
                                 $urandom_range(1, SSTEP_TOP), $urandom_range(0, JOY_FULL),
                                 $urandom_range(0, JOY_FULL), $urandom_range(1, JOY_FULL),
                                 $urandom_range(1, JOY_FULL));
        plans[NUM_PLANS-1] = live_plan;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed steps under the reset settings: echo at zero, one, the
        // range limit and just above it, full scale, alternating bit patterns,
        // both toggles, the largest joystick moves and each deadzone edge.
        send_step(12'd0,    16'd0,     1'b0, 1'b0);
        send_step(12'd4095, 16'd1,     1'b0, 1'b0);
        send_step(12'd2048, ECHO_LIMIT, 1'b0, 1'b0);
        send_step(12'd2048, ECHO_LIMIT + 16'd1, 1'b0, 1'b0);
        send_step(12'd4095, 16'hFFFF,  1'b1, 1'b0);
        send_step(12'h555,  16'hAAAA,  1'b0, 1'b0);
        send_step(12'hAAA,  16'h5555,  1'b0, 1'b0);
        send_step(12'd0,    16'd58,    1'b0, 1'b1);
        send_step(12'd4095, 16'd100,   1'b0, 1'b0);
        send_step(12'd2899, 16'd583,   1'b0, 1'b0);
        send_step(12'd2900, 16'd584,   1'b0, 1'b0);
        send_step(12'd3400, 16'd29999, 1'b0, 1'b0);
        send_step(12'd3401, 16'd15000, 1'b0, 1'b0);
        send_step(12'd3150, 16'd7777,  1'b1, 1'b0);
        send_step(12'd1234, 16'd20000, 1'b1, 1'b1);
        send_step(12'd0,    16'd10000, 1'b0, 1'b1);
        send_step(12'd2730, 16'd12345, 1'b0, 1'b1);
        drain_results();

        // Random phases. Idling goes sender-light/receiver-heavy first, then
        // the reverse, then none at all. Two phases start with a long
        // receiver hold-off while steps keep coming, and one pauses half way
        // until every result is back.
        rand_steps = 0;
        for (p = 0; p < NUM_PLANS; p++)
        begin
            load_plan(plans[p]);
            if (p == HOLD_PLAN_A || p == HOLD_PLAN_B)
                hold_asked <= hold_asked + 1;
            for (k = 0; k < STEPS_PER_PLAN; k++)
            begin
                if (p == PAUSE_PLAN && k == STEPS_PER_PLAN / 2)
                    drain_results();
                if (rand_steps < PHASE_A_END)
                begin
                    send_idle_pct <= 15;
                    recv_idle_pct <= 49;
                end
                else if (rand_steps < PHASE_B_END)
                begin
                    send_idle_pct <= 49;
                    recv_idle_pct <= 15;
                end
                else
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
                send_random_step();
                rand_steps = rand_steps + 1;
            end
            drain_results();
        end

        $display("Covered %0d scan steps over %0d register settings, auto and manual modes,",
                 steps_sent, NUM_PLANS);
        $display("sweep turns, range errors and long receiver stalls; %0d results compared.",
                 reports_checked);
        if (mismatches == 0 && in_flight == 0)
            $display("servo_scan_position_controller_tb: clean");
        else
            $display("servo_scan_position_controller_tb: errors");
        $finish;
    end

endmodule
